>>> src/psm_pkg.sv
// Shared constants, types and helpers of the pair sum matcher.
package psm_pkg;

    localparam int STORE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int COUNT_W     = $clog2(STORE_DEPTH + 1);
    localparam int VALUE_W     = 32;
    localparam int POS_W       = 6;
    localparam int STATUS_W    = 3;
    localparam int POS_MAX     = (STORE_DEPTH - 1 < 63) ? STORE_DEPTH - 1 : 63;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [STATUS_W-1:0] ST_NONE    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_PAIR    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOPAIR  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_IGNORED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;

    // One classified input item as it sits in the queue.
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [VALUE_W-1:0] wanted;
        logic               wanted_ok;
        logic               start;
        logic               last;
    } item_t;

    // Saturate a slot or item position to the width of the position fields.
    function automatic logic [POS_W-1:0] clip_pos(input logic [COUNT_W-1:0] p);
        logic [31:0] w;
        w = 32'(p);
        if (w > 32'(POS_MAX))
        begin
            return POS_W'(POS_MAX);
        end
        return w[POS_W-1:0];
    endfunction

endpackage

>>> src/psm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module psm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

>>> src/psm_front.sv
// Front end: holds the target sum and classifies each accepted item.
module psm_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [psm_pkg::VALUE_W-1:0] value,
    input  logic                          start_flag,
    input  logic                          last_flag,
    input  logic                          cfg_wr_en,
    input  logic signed [psm_pkg::VALUE_W-1:0] cfg_wr_data,
    output logic                          push_valid,
    input  logic                          push_stall,
    output psm_pkg::item_t                push_item
);
    import psm_pkg::*;

    logic [VALUE_W-1:0] target_reg;
    logic [VALUE_W-1:0] target_next;
    logic [VALUE_W:0]   diff;

    always_comb
    begin
        target_next = cfg_wr_en ? VALUE_W'(cfg_wr_data) : target_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= '0;
        end
        else
        begin
            target_reg <= target_next;
        end
    end

    // Exact difference on one extra bit; it fits in 32 bits when the top two agree.
    assign diff = {target_reg[VALUE_W-1], target_reg} - {value[VALUE_W-1], value};

    assign push_valid          = in_valid;
    assign in_stall            = push_stall;
    assign push_item.value     = VALUE_W'(value);
    assign push_item.wanted    = diff[VALUE_W-1:0];
    assign push_item.wanted_ok = (diff[VALUE_W] == diff[VALUE_W-1]);
    assign push_item.start     = start_flag;
    assign push_item.last      = last_flag;
endmodule

>>> src/psm_queue.sv
// Short queue of classified items between the front and the back end.
module psm_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_stall,
    input  psm_pkg::item_t push_item,
    output logic           pop_valid,
    input  logic           pop_stall,
    output psm_pkg::item_t pop_item
);
    import psm_pkg::*;

    item_t             slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   fill_reg, fill_next;
    logic              push, pop;

    assign push_stall = (fill_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && !push_stall;
    assign pop        = pop_valid && !pop_stall;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        unique case ({push, pop})
            2'b10:   fill_next = fill_reg + 1'b1;
            2'b01:   fill_next = fill_reg - 1'b1;
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end
endmodule

>>> src/psm_back.sv
// Back end: scans the value store, updates the array state and holds the result.
module psm_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           pop_valid,
    output logic                           pop_stall,
    input  psm_pkg::item_t                 pop_item,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [psm_pkg::STATUS_W-1:0]   status,
    output logic [psm_pkg::POS_W-1:0]      earlier_position,
    output logic [psm_pkg::POS_W-1:0]      later_position
);
    import psm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_FINISH = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic                done_reg, done_next;
    item_t               cur_reg, cur_next;
    logic [ADDR_W-1:0]   scan_addr_reg, scan_addr_next;
    logic                hit_reg, hit_next;
    logic                ign_reg, ign_next;
    logic [ADDR_W-1:0]   hit_addr_reg, hit_addr_next;

    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [POS_W-1:0]    earlier_reg, earlier_next;
    logic [POS_W-1:0]    later_reg, later_next;

    logic                rd_en, wr_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic [VALUE_W-1:0]  rd_data;
    logic [COUNT_W-1:0]  eff_count, count_m1;
    logic                eff_done, room, out_free;

    psm_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data (cur_reg.value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign pop_stall = (state_reg != S_IDLE);
    assign eff_count = pop_item.start ? '0 : count_reg;
    assign eff_done  = pop_item.start ? 1'b0 : done_reg;
    assign count_m1  = eff_count - COUNT_W'(1);
    assign room      = (count_reg < COUNT_W'(STORE_DEPTH));
    assign out_free  = !out_valid_reg || !out_stall;
    assign wr_en     = (state_reg == S_FINISH) && out_free && !ign_reg && !hit_reg && room;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        done_next      = done_reg;
        cur_next       = cur_reg;
        scan_addr_next = scan_addr_reg;
        hit_next       = hit_reg;
        ign_next       = ign_reg;
        hit_addr_next  = hit_addr_reg;
        out_valid_next = out_valid_reg && out_stall;
        status_next    = status_reg;
        earlier_next   = earlier_reg;
        later_next     = later_reg;
        rd_en          = 1'b0;
        rd_addr        = scan_addr_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (pop_valid)
                begin
                    cur_next   = pop_item;
                    count_next = eff_count;
                    done_next  = eff_done;
                    hit_next   = 1'b0;
                    ign_next   = eff_done;
                    if (eff_done || !pop_item.wanted_ok || (eff_count == '0))
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        rd_en          = 1'b1;
                        rd_addr        = count_m1[ADDR_W-1:0];
                        scan_addr_next = count_m1[ADDR_W-1:0];
                        state_next     = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                // Newest slot first, so the first match is the most recent one.
                if (rd_data == cur_reg.wanted)
                begin
                    hit_next      = 1'b1;
                    hit_addr_next = scan_addr_reg;
                    state_next    = S_FINISH;
                end
                else if (scan_addr_reg == '0)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    rd_en          = 1'b1;
                    rd_addr        = scan_addr_reg - 1'b1;
                    scan_addr_next = scan_addr_reg - 1'b1;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    if (ign_reg)
                    begin
                        status_next  = ST_IGNORED;
                        earlier_next = '0;
                        later_next   = '0;
                    end
                    else
                    begin
                        later_next = clip_pos(count_reg);
                        if (room)
                        begin
                            count_next = count_reg + 1'b1;
                        end
                        if (hit_reg)
                        begin
                            status_next  = ST_PAIR;
                            earlier_next = clip_pos(COUNT_W'(hit_addr_reg));
                            done_next    = 1'b1;
                        end
                        else
                        begin
                            earlier_next = '0;
                            if (cur_reg.last)
                            begin
                                status_next = ST_NOPAIR;
                                done_next   = 1'b1;
                            end
                            else if (room)
                            begin
                                status_next = ST_NONE;
                            end
                            else
                            begin
                                status_next = ST_FULL;
                            end
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        scan_addr_reg <= scan_addr_next;
        hit_reg       <= hit_next;
        ign_reg       <= ign_next;
        hit_addr_reg  <= hit_addr_next;
        status_reg    <= status_next;
        earlier_reg   <= earlier_next;
        later_reg     <= later_next;
    end

    assign out_valid        = out_valid_reg;
    assign status           = status_reg;
    assign earlier_position = earlier_reg;
    assign later_position   = later_reg;
endmodule

>>> src/pair_sum_matcher_core.sv
// Top level of the pair sum matcher: front end, item queue and back end.
//
// Usage. Input transactions carry one signed 32-bit value with start and
// last flags; a transaction completes on a rising edge with in_valid high and
// in_stall low. Every input transaction yields exactly one output transaction
// (status, earlier_position, later_position), handed over when out_valid is
// high and out_stall is low. The target sum is written through cfg_wr_en and
// cfg_wr_data, and must only be changed while the block has no work in hand.
// Scan. The back end compares the wanted partner against the stored
// values one memory read per cycle, newest first, through the single read
// port of the value memory. It takes a new item from the queue only when it
// is idle again; an accepted item passes through the queue, the scan if the
// store holds values, and the finish state, which writes the result into
// the output register.
// Reset. All control state clears: the store counts as empty and an array is
// treated as started. The value memory itself is not cleared; a fill count
// marks which slots hold data. The target sum resets to zero.
// Stalls. A stalled result stays in the output register; the back end then
// waits, the two-entry queue fills and in_stall rises until it drains.
module pair_sum_matcher_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [psm_pkg::VALUE_W-1:0]  value,
    input  logic                                start_flag,
    input  logic                                last_flag,
    input  logic                                cfg_wr_en,
    input  logic signed [psm_pkg::VALUE_W-1:0]  cfg_wr_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [psm_pkg::STATUS_W-1:0]        status,
    output logic [psm_pkg::POS_W-1:0]           earlier_position,
    output logic [psm_pkg::POS_W-1:0]           later_position
);
    import psm_pkg::*;

    // Classified items travel from the front end to the queue.
    item_t push_item;
    logic  push_valid;
    logic  push_stall;

    // And from the queue on to the back end.
    item_t pop_item;
    logic  pop_valid;
    logic  pop_stall;

    // The front end works out target minus value exactly and notes whether it
    // can match any 32-bit stored value at all.
    psm_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .value       (value),
        .start_flag  (start_flag),
        .last_flag   (last_flag),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .push_valid  (push_valid),
        .push_stall  (push_stall),
        .push_item   (push_item)
    );

    // The queue lets the input side keep taking transactions while the back
    // end is busy scanning or its result is held up.
    psm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_stall (push_stall),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_stall  (pop_stall),
        .pop_item   (pop_item)
    );

    // The back end owns the value store, the fill count and the finished flag.
    psm_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .pop_valid        (pop_valid),
        .pop_stall        (pop_stall),
        .pop_item         (pop_item),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .status           (status),
        .earlier_position (earlier_position),
        .later_position   (later_position)
    );
endmodule

>>> dv/pair_sum_matcher_core_tb.sv
// Self-checking testbench for the pair sum matcher core.
`timescale 1ns / 1ps

module pair_sum_matcher_core_tb;

    import psm_pkg::*;

    // Cycles without any accepted transaction before the run is declared hung.
    // The limit lies many times above the longest scan of a full store by the
    // back end and above the long hold-off of the receiver.
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int HOLD_OFF_CYCLES = 150;
    localparam int DRAIN_CYCLES    = STORE_DEPTH + 16;
    localparam int ITEMS_PER_PHASE = 325;
    localparam int PHASE_COUNT     = 6;
    localparam int MAX_PRINTED     = 40;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    earlier;
        logic [POS_W-1:0]    later;
    } match_result_t;

    typedef struct {
        logic signed [VALUE_W-1:0] val;
        bit                        start;
        bit                        last;
        bit                        typed;
        match_result_t             res;
    } directed_item_t;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic signed [VALUE_W-1:0]  value;
    logic                       start_flag;
    logic                       last_flag;
    logic                       cfg_wr_en;
    logic signed [VALUE_W-1:0]  cfg_wr_data;
    logic                       out_valid;
    logic                       out_stall;
    logic [STATUS_W-1:0]        status;
    logic [POS_W-1:0]           earlier_position;
    logic [POS_W-1:0]           later_position;

    pair_sum_matcher_core uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .value            (value),
        .start_flag       (start_flag),
        .last_flag        (last_flag),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .status           (status),
        .earlier_position (earlier_position),
        .later_position   (later_position)
    );

    // Shadow copy of the matcher's state: the values stored for the current
    // array, which slots hold one, the position of the next item, whether the
    // array is already finished, and the target sum in force.
    logic signed [VALUE_W-1:0] shadow_values [STORE_DEPTH];
    bit                        shadow_held   [STORE_DEPTH];
    int                        next_position;
    bit                        array_closed;
    logic signed [VALUE_W-1:0] target_model;

    // Results still owed by the block, oldest first.
    match_result_t pending_results [$];

    int  error_count;
    int  counted_items;
    bit  steady_sender;
    bit  steady_receiver;
    bit  hold_off_request;

    // Directed items, all under the reset target of zero. Results are typed
    // in where they are obvious; the rest are left to the predictor.
    directed_item_t directed_items [21] = '{
        // Before any start the block behaves as if an array had begun.
        '{32'sd5,            1'b0, 1'b0, 1'b1, '{ST_NONE,    6'd0, 6'd0}},
        '{-32'sd5,           1'b0, 1'b0, 1'b1, '{ST_PAIR,    6'd0, 6'd1}},
        // A finished array ignores everything until the next start.
        '{32'sd7,            1'b0, 1'b0, 1'b1, '{ST_IGNORED, 6'd0, 6'd0}},
        '{32'sd7,            1'b0, 1'b1, 1'b1, '{ST_IGNORED, 6'd0, 6'd0}},
        // Extremes: the partner of the most negative value lies out of range.
        '{32'sh7FFF_FFFF,    1'b1, 1'b0, 1'b1, '{ST_NONE,    6'd0, 6'd0}},
        '{32'sh8000_0000,    1'b0, 1'b0, 1'b1, '{ST_NONE,    6'd0, 6'd1}},
        '{32'sh8000_0001,    1'b0, 1'b0, 1'b1, '{ST_PAIR,    6'd0, 6'd2}},
        // Two equal candidates: the newer one must be reported.
        '{32'sd3,            1'b1, 1'b0, 1'b0, '0},
        '{32'sd3,            1'b0, 1'b0, 1'b0, '0},
        '{-32'sd3,           1'b0, 1'b0, 1'b0, '0},
        // A one-item array ends with no pair.
        '{32'sd0,            1'b1, 1'b1, 1'b1, '{ST_NOPAIR,  6'd0, 6'd0}},
        '{32'sd0,            1'b0, 1'b0, 1'b1, '{ST_IGNORED, 6'd0, 6'd0}},
        // A hit on the last item is still a pair.
        '{32'sd0,            1'b1, 1'b0, 1'b0, '0},
        '{32'sd0,            1'b0, 1'b1, 1'b0, '0},
        '{-32'sd1,           1'b1, 1'b0, 1'b0, '0},
        '{32'sd1,            1'b0, 1'b1, 1'b0, '0},
        // A start in the middle of an array discards what was stored.
        '{-32'sd2,           1'b1, 1'b0, 1'b0, '0},
        '{32'sd2,            1'b1, 1'b0, 1'b0, '0},
        '{-32'sd2,           1'b0, 1'b0, 1'b0, '0},
        // Two most negative values sum far below the 32-bit range.
        '{32'sh8000_0000,    1'b1, 1'b0, 1'b0, '0},
        '{32'sh8000_0000,    1'b0, 1'b1, 1'b0, '0}
    };

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    // Saturate a position to what the position fields can show.
    function automatic logic [POS_W-1:0] saturate_position(input int p);
        return (p > POS_MAX) ? POS_W'(POS_MAX) : POS_W'(p);
    endfunction

    // Work out the result of one accepted item and advance the shadow state.
    function automatic match_result_t predict_match(input logic signed [VALUE_W-1:0] v,
                                                    input bit s, input bit l);
        match_result_t r;
        longint        wanted;
        int            hit;
        if (s)
        begin
            foreach (shadow_held[i])
            begin
                shadow_held[i] = 1'b0;
            end
            next_position = 0;
            array_closed  = 1'b0;
        end
        r = '{ST_IGNORED, '0, '0};
        if (array_closed)
        begin
            return r;
        end
        r.later = saturate_position(next_position);
        // The partner is formed in 64 bits, so a sum beyond the 32-bit range
        // can never compare equal to a stored value.
        wanted = longint'(target_model) - longint'(v);
        hit = -1;
        for (int i = STORE_DEPTH - 1; i >= 0; i--)
        begin
            if (hit < 0 && shadow_held[i] && longint'(shadow_values[i]) == wanted)
            begin
                hit = i;
            end
        end
        if (hit >= 0)
        begin
            r.status     = ST_PAIR;
            r.earlier    = saturate_position(hit);
            array_closed = 1'b1;
        end
        else
        begin
            if (next_position < STORE_DEPTH)
            begin
                shadow_values[next_position] = v;
                shadow_held[next_position]   = 1'b1;
                r.status = ST_NONE;
            end
            else
            begin
                r.status = ST_FULL;
            end
            if (l)
            begin
                r.status     = ST_NOPAIR;
                array_closed = 1'b1;
            end
        end
        if (next_position < STORE_DEPTH)
        begin
            next_position++;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (error_count < MAX_PRINTED)
        begin
            $display("%0t mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
        end
        error_count++;
    endtask

    // Offer one input transaction after a random gap (none while the sender is steady) and hold it until the
    // block takes it; the expectation is recorded at the accepting edge.
    task automatic send_item(input logic signed [VALUE_W-1:0] v, input bit s, input bit l,
                             input bit typed = 1'b0, input match_result_t typed_res = '0);
        int            gap;
        match_result_t model_res;
        gap = steady_sender ? 0 : $urandom_range(0, 3);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        value      <= v;
        start_flag <= s;
        last_flag  <= l;
        do @(posedge clk); while (in_stall);
        model_res = predict_match(v, s, l);
        pending_results.push_back(typed ? typed_res : model_res);
        counted_items++;
    endtask

    // Withdraw the input, let every owed result arrive, then write the target.
    task automatic write_target(input logic signed [VALUE_W-1:0] t);
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= t;
        @(negedge clk);
        cfg_wr_en    <= 1'b0;
        target_model = t;
    endtask

    // Choose the next value of an array. Partners of earlier members make
    // hits likely; wide arrays use raw random values so that the store fills
    // and only near the top do they try for a hit in a deep slot.
    function automatic logic signed [VALUE_W-1:0] pick_value(
            input logic signed [VALUE_W-1:0] members [$], input bit wide);
        int roll;
        roll = $urandom_range(0, 99);
        if (members.size() > 0 && (wide ? (members.size() >= 58 && roll < 10) : roll < 30))
        begin
            return target_model - members[$urandom_range(0, members.size() - 1)];
        end
        if (wide || roll >= 65)
        begin
            return $urandom;
        end
        if (roll < 55)
        begin
            return VALUE_W'(int'($urandom_range(0, 16)) - 8);
        end
        case ($urandom_range(0, 5))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2: return 32'sd0;
            3: return -32'sd1;
            4: return target_model;
            default: return target_model ^ 32'sh8000_0000;
        endcase
    endfunction

    // One random array: mostly well-formed arrays of random content, a few
    // long ones, of up to 70 items, that can overflow the store, and some loose items without a start.
    task automatic send_array();
        logic signed [VALUE_W-1:0] members [$];
        logic signed [VALUE_W-1:0] v;
        int                        kind;
        int                        len;
        bit                        wide;
        bit                        closing;
        kind = $urandom_range(0, 99);
        steady_sender = ($urandom_range(0, 9) == 0);
        if (kind < 14)
        begin
            len = $urandom_range(1, 4);
            for (int i = 0; i < len; i++)
            begin
                send_item($urandom, 1'b0, 1'($urandom_range(0, 1)));
            end
        end
        else
        begin
            wide    = (kind >= 94);
            len     = wide ? $urandom_range(62, 70) : $urandom_range(1, 12);
            closing = ($urandom_range(0, 9) < 8);
            for (int i = 0; i < len; i++)
            begin
                v = pick_value(members, wide);
                send_item(v, i == 0, closing && i == len - 1);
                members.push_back(v);
            end
        end
    endtask

    // Stimulus: reset, the directed items, then phases of random arrays, each
    // under a target sum written while the block is idle.
    initial
    begin
        rst_n            = 1'b0;
        in_valid         = 1'b0;
        value            = '0;
        start_flag       = 1'b0;
        last_flag        = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_wr_data      = '0;
        error_count      = 0;
        counted_items    = 0;
        steady_sender    = 1'b0;
        hold_off_request = 1'b0;
        target_model     = '0;
        next_position    = 0;
        array_closed     = 1'b0;
        foreach (shadow_held[i])
        begin
            shadow_held[i]   = 1'b0;
            shadow_values[i] = '0;
        end
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_items[i])
        begin
            send_item(directed_items[i].val, directed_items[i].start, directed_items[i].last,
                      directed_items[i].typed, directed_items[i].res);
        end

        counted_items = 0;
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            case (p)
                0: write_target(32'sh7FFF_FFFF);
                1: write_target(32'sh8000_0000);
                2: write_target(-32'sd1);
                3: write_target($urandom);
                4: write_target(32'sd0);
                default: write_target(VALUE_W'(int'($urandom_range(0, 20)) - 10));
            endcase
            // Early in the second phase the receiver stops for a long stretch
            // while items keep coming, so the block has to stall its input.
            if (p == 1)
            begin
                hold_off_request = 1'b1;
            end
            while (counted_items < (p + 1) * ITEMS_PER_PHASE)
            begin
                send_array();
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Receiver: before each output transaction it may hold off at random,
    // not at all during steady stretches, or for the long
    // hold-off when that has been asked for.
    initial
    begin
        int wait_cycles;
        out_stall       = 1'b0;
        steady_receiver = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 31) == 0)
            begin
                steady_receiver = !steady_receiver;
            end
            wait_cycles = steady_receiver ? 0 : $urandom_range(0, 3);
            if (hold_off_request)
            begin
                wait_cycles      = HOLD_OFF_CYCLES;
                hold_off_request = 1'b0;
            end
            @(negedge clk);
            if (wait_cycles > 0)
            begin
                out_stall <= 1'b1;
                repeat (wait_cycles) @(negedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    // Compare every accepted result, field by field, with the oldest one owed.
    always @(posedge clk)
    begin : result_check
        match_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("unrequested result, status", status, -1);
            end
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status)
                begin
                    report_mismatch("status", status, want.status);
                end
                if (earlier_position !== want.earlier)
                begin
                    report_mismatch("earlier_position", earlier_position, want.earlier);
                end
                if (later_position !== want.later)
                begin
                    report_mismatch("later_position", later_position, want.later);
                end
            end
        end
    end

    // Watchdog: any cycle in which neither side completes a transaction
    // counts towards the limit; one that does resets the count.
    always @(posedge clk)
    begin : watchdog
        int quiet_cycles;
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t watchdog: no transaction for %0d cycles", $realtime, quiet_cycles);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

endmodule

>>> filelist.f
src/psm_pkg.sv
src/psm_ram.sv
src/psm_front.sv
src/psm_queue.sv
src/psm_back.sv
src/pair_sum_matcher_core.sv
dv/pair_sum_matcher_core_tb.sv
